// ===== design/cfr_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the clock frame replacer
package cfr_pkg;

	localparam int TYPE_W  = 3;
	localparam int FRAME_W = 6;

	// request codes
	localparam logic [TYPE_W-1:0] REQ_ACQUIRE     = 3'd0;
	localparam logic [TYPE_W-1:0] REQ_SET_PIN     = 3'd1;
	localparam logic [TYPE_W-1:0] REQ_MARK_DIRTY  = 3'd2;
	localparam logic [TYPE_W-1:0] REQ_CLEAR_DIRTY = 3'd3;
	localparam logic [TYPE_W-1:0] REQ_FREE        = 3'd4;

	// result status codes
	localparam logic STATUS_OK         = 1'b0;
	localparam logic STATUS_ALL_PINNED = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} cfr_state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cfr_cmd_t;

endpackage

// ===== design/cfr_req_if.sv =====
`timescale 1ns / 1ps
// request channel interface
interface cfr_req_if
	import cfr_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [TYPE_W-1:0]  req_type;
	logic [FRAME_W-1:0] frame_index;
	logic               pin_flag;

	modport source (output valid, output req_type, output frame_index, output pin_flag,
		input ready);
	modport sink (input valid, input req_type, input frame_index, input pin_flag,
		output ready);
endinterface

// ===== design/cfr_rsp_if.sv =====
`timescale 1ns / 1ps
// result channel interface
interface cfr_rsp_if
	import cfr_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [FRAME_W-1:0] frame;
	logic               write_back;
	logic               status;

	modport source (output valid, output frame, output write_back, output status,
		input ready);
	modport sink (input valid, input frame, input write_back, input status,
		output ready);
endinterface

// ===== design/cfr_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine: capture, execute and result valid
module cfr_ctrl
	import cfr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output cfr_cmd_t cmd
);

	cfr_state_t state_q, state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// wait until the output register is free or being emptied
				if (!out_valid_q || rsp_ready) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

// ===== design/cfr_datapath.sv =====
`timescale 1ns / 1ps
// frame state bits, free and victim search, result register
module cfr_datapath
	import cfr_pkg::*;
#(
	parameter int NUM_FRAMES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfr_cmd_t           cmd,
	input  logic [TYPE_W-1:0]  req_type,
	input  logic [FRAME_W-1:0] frame_index,
	input  logic               pin_flag,
	output logic [FRAME_W-1:0] frame,
	output logic               write_back,
	output logic               status
);

	localparam int FW = $clog2(NUM_FRAMES);
	localparam int CW = $clog2(NUM_FRAMES + 1);
	localparam int IW = ((FW > FRAME_W) ? FW : FRAME_W) + 1;

	logic [NUM_FRAMES-1:0] valid_q, pin_q, ref_q, dirty_q;
	logic [CW-1:0]         used_q;
	logic [FW-1:0]         hand_q;

	logic [TYPE_W-1:0]  type_q;
	logic [FRAME_W-1:0] idx_q;
	logic               pin_q_in;

	logic [FRAME_W-1:0] frame_q;
	logic               wb_q;
	logic               status_q;

	logic [NUM_FRAMES-1:0] cand, sel, sel_hi, above, between, ref_swept;
	logic [FW-1:0]         free_idx, lo_idx, hi_idx, vic_idx, f_idx;
	logic                  free_found, hi_found, vic_found, take_free, in_range;
	logic [IW-1:0]         idx_w, free_w, vic_w;

	// capture the transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q   <= req_type;
			idx_q    <= frame_index;
			pin_q_in <= pin_flag;
		end
	end

	assign idx_w    = IW'(idx_q);
	assign in_range = idx_w < IW'(NUM_FRAMES);
	assign f_idx    = idx_w[FW-1:0];

	// lowest free frame
	always_comb begin
		free_idx   = '0;
		free_found = 1'b0;
		for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx   = FW'(i);
				free_found = 1'b1;
			end
		end
	end

	assign take_free = (used_q < CW'(NUM_FRAMES)) && free_found;

	// second chance: unreferenced unpinned frames first, else any unpinned frame
	assign cand = ~pin_q & ~ref_q;
	assign sel  = (|cand) ? cand : ~pin_q;

	always_comb begin
		for (int i = 0; i < NUM_FRAMES; i++) begin
			above[i] = FW'(i) > hand_q;
		end
	end

	assign sel_hi = sel & above;

	always_comb begin
		lo_idx    = '0;
		hi_idx    = '0;
		hi_found  = 1'b0;
		for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
			if (sel[i]) begin
				lo_idx = FW'(i);
			end
			if (sel_hi[i]) begin
				hi_idx   = FW'(i);
				hi_found = 1'b1;
			end
		end
	end

	assign vic_idx   = hi_found ? hi_idx : lo_idx;
	assign vic_found = |sel;

	// frames the hand passes over on its way to the victim
	always_comb begin
		for (int i = 0; i < NUM_FRAMES; i++) begin
			if (vic_idx > hand_q) begin
				between[i] = (FW'(i) > hand_q) && (FW'(i) < vic_idx);
			end else begin
				between[i] = (FW'(i) > hand_q) || (FW'(i) < vic_idx);
			end
		end
	end

	// with no unreferenced candidate a whole lap clears every unpinned bit
	assign ref_swept = (|cand) ? (ref_q & ~(between & ~pin_q)) : (ref_q & pin_q);

	assign free_w = IW'(free_idx);
	assign vic_w  = IW'(vic_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			pin_q   <= '0;
			ref_q   <= '0;
			dirty_q <= '0;
			used_q  <= '0;
			hand_q  <= FW'(NUM_FRAMES - 1);
		end else if (cmd.exec) begin
			case (type_q)
				REQ_ACQUIRE: begin
					if (take_free) begin
						valid_q[free_idx] <= 1'b1;
						pin_q[free_idx]   <= pin_q_in;
						ref_q[free_idx]   <= ~pin_q_in;
						dirty_q[free_idx] <= 1'b0;
						used_q            <= used_q + CW'(1);
					end else if (vic_found) begin
						ref_q            <= ref_swept;
						ref_q[vic_idx]   <= ~pin_q_in;
						valid_q[vic_idx] <= 1'b1;
						pin_q[vic_idx]   <= pin_q_in;
						dirty_q[vic_idx] <= 1'b0;
						hand_q           <= vic_idx;
					end else begin
						hand_q <= FW'(NUM_FRAMES - 1);
					end
				end
				REQ_SET_PIN: begin
					if (in_range && valid_q[f_idx]) begin
						pin_q[f_idx] <= pin_q_in;
						if (!pin_q_in) begin
							ref_q[f_idx] <= 1'b1;
						end
					end
				end
				REQ_MARK_DIRTY: begin
					if (in_range && valid_q[f_idx]) begin
						dirty_q[f_idx] <= 1'b1;
					end
				end
				REQ_CLEAR_DIRTY: begin
					if (in_range && valid_q[f_idx]) begin
						dirty_q[f_idx] <= 1'b0;
					end
				end
				REQ_FREE: begin
					if (in_range && valid_q[f_idx]) begin
						valid_q[f_idx] <= 1'b0;
						pin_q[f_idx]   <= 1'b0;
						ref_q[f_idx]   <= 1'b0;
						dirty_q[f_idx] <= 1'b0;
						if (used_q != '0) begin
							used_q <= used_q - CW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (type_q == REQ_ACQUIRE) begin
				if (take_free) begin
					frame_q  <= free_w[FRAME_W-1:0];
					wb_q     <= 1'b0;
					status_q <= STATUS_OK;
				end else if (vic_found) begin
					frame_q  <= vic_w[FRAME_W-1:0];
					wb_q     <= dirty_q[vic_idx];
					status_q <= STATUS_OK;
				end else begin
					frame_q  <= '0;
					wb_q     <= 1'b0;
					status_q <= STATUS_ALL_PINNED;
				end
			end else begin
				frame_q  <= idx_q;
				wb_q     <= 1'b0;
				status_q <= STATUS_OK;
			end
		end
	end

	assign frame      = frame_q;
	assign write_back = wb_q;
	assign status     = status_q;

endmodule

// ===== design/clock_frame_replacer_unit.sv =====
`timescale 1ns / 1ps
// top level of the clock frame replacer
//
//   channel | dir | payload                        | handshake
//   req     | in  | req_type, frame_index, pin_flag | valid / ready
//   rsp     | out | frame, write_back, status       | valid / ready
//
// a transaction is captured in the idle state, then the exec state runs the
// free frame and clock victim search and the state update, which fill the
// result register; no new request is taken in the exec state. a new request
// is taken while the previous result waits; the update stalls only while the
// result register still holds an untaken result. reset leaves every frame
// free, the used count at zero and the hand on the last frame.
module clock_frame_replacer_unit
	import cfr_pkg::*;
#(
	parameter int NUM_FRAMES = 64
) (
	input  logic clk,
	input  logic arst_n,
	cfr_req_if.sink   req,
	cfr_rsp_if.source rsp
);

	cfr_cmd_t cmd;
	logic     req_ready;
	logic     rsp_valid;

	cfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	cfr_datapath #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.req_type    (req.req_type),
		.frame_index (req.frame_index),
		.pin_flag    (req.pin_flag),
		.frame       (rsp.frame),
		.write_back  (rsp.write_back),
		.status      (rsp.status)
	);

	assign req.ready = req_ready;
	assign rsp.valid = rsp_valid;

endmodule

// ===== tb/sv/tb_clock_frame_replacer_unit.sv =====
`timescale 1ns / 1ps
// testbench for the clock frame replacer: directed and random requests checked by a scoreboard
module tb_clock_frame_replacer_unit;
	import cfr_pkg::*;

	localparam int POOL_SIZE       = 64;
	localparam int CLK_HALF        = 5;
	localparam int ITEMS_PER_PHASE = 630;
	localparam int SETTLE_CYCLES   = 8;
	localparam int MAX_REPORTS     = 10;
	localparam int TIMEOUT_NS      = 2_000_000;
	localparam logic [TYPE_W-1:0] REQ_TOP_CODE = '1;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic               write_back;
		logic               status;
	} reply_t;

	// mirror of the frame pool, predicts one reply per accepted request
	class frame_pool_scoreboard;
		bit          resident[POOL_SIZE];
		bit          pinned[POOL_SIZE];
		bit          referenced[POOL_SIZE];
		bit          dirty[POOL_SIZE];
		int unsigned used_frames;
		int unsigned hand;
		reply_t      awaited_replies[$];
		int          failures;
		int          requests_seen;
		int          fresh_grants;
		int          victim_grants;
		int          flushes;
		int          pool_exhausted;

		function new();
			foreach (resident[i]) begin
				resident[i]   = 1'b0;
				pinned[i]     = 1'b0;
				referenced[i] = 1'b0;
				dirty[i]      = 1'b0;
			end
			used_frames = 0;
			hand        = POOL_SIZE - 1;
		endfunction

		function void load(int unsigned f, bit pin);
			dirty[f]      = 1'b0;
			referenced[f] = !pin;
			pinned[f]     = pin;
			resident[f]   = 1'b1;
		endfunction

		function reply_t choose_frame(bit pin);
			reply_t      r;
			int unsigned h;
			r = '{frame: '0, write_back: 1'b0, status: STATUS_OK};
			if (used_frames < POOL_SIZE) begin
				for (h = 0; h < POOL_SIZE; h++) begin
					if (!resident[h]) begin
						load(h, pin);
						used_frames++;
						fresh_grants++;
						r.frame = h[FRAME_W-1:0];
						return r;
					end
				end
			end
			h = hand;
			for (int step = 0; step <= 2 * POOL_SIZE; step++) begin
				h = (h + 1 >= POOL_SIZE) ? 0 : h + 1;
				if (pinned[h])
					continue;
				// second chance: clear the reference bit and move on
				if (referenced[h]) begin
					referenced[h] = 1'b0;
					continue;
				end
				r.write_back = dirty[h];
				load(h, pin);
				hand = h;
				r.frame = h[FRAME_W-1:0];
				victim_grants++;
				if (r.write_back)
					flushes++;
				return r;
			end
			hand = POOL_SIZE - 1;
			r.status = STATUS_ALL_PINNED;
			pool_exhausted++;
			return r;
		endfunction

		function void note_request(logic [TYPE_W-1:0] kind, logic [FRAME_W-1:0] idx,
			logic pin);
			reply_t      r;
			int unsigned f;
			requests_seen++;
			if (kind == REQ_ACQUIRE) begin
				awaited_replies.push_back(choose_frame(pin));
				return;
			end
			r = '{frame: idx, write_back: 1'b0, status: STATUS_OK};
			awaited_replies.push_back(r);
			f = idx;
			if (f >= POOL_SIZE || !resident[f])
				return;
			case (kind)
				REQ_SET_PIN: begin
					pinned[f] = pin;
					if (!pin)
						referenced[f] = 1'b1;
				end
				REQ_MARK_DIRTY:  dirty[f] = 1'b1;
				REQ_CLEAR_DIRTY: dirty[f] = 1'b0;
				REQ_FREE: begin
					resident[f]   = 1'b0;
					pinned[f]     = 1'b0;
					referenced[f] = 1'b0;
					dirty[f]      = 1'b0;
					if (used_frames > 0)
						used_frames--;
				end
				default: ;
			endcase
		endfunction

		function void check_result(reply_t got);
			reply_t want;
			if (awaited_replies.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("[%0t] reply with nothing outstanding: %s %0d wb %0b status %0b",
						$time, "frame", got.frame, got.write_back, got.status);
				return;
			end
			want = awaited_replies.pop_front();
			if (got.frame !== want.frame || got.write_back !== want.write_back ||
				got.status !== want.status) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("[%0t] reply mismatch: frame exp %0d act %0d, %s %0b act %0b, %s %0b act %0b",
						$time, want.frame, got.frame, "wb exp", want.write_back,
						got.write_back, "status exp", want.status, got.status);
			end
		endfunction

		function int pending();
			return awaited_replies.size();
		endfunction

		function void close_out();
			if (awaited_replies.size() != 0) begin
				$display("%0d replies never arrived", awaited_replies.size());
				failures += awaited_replies.size();
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   tx_idle_pct;
	int   rx_idle_pct;

	cfr_req_if req_ch ();
	cfr_rsp_if rsp_ch ();

	frame_pool_scoreboard sb;

	clock_frame_replacer_unit #(
		.NUM_FRAMES(POOL_SIZE)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// transactions on both channels, sampled at the edge that completes them
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			sb.note_request(req_ch.req_type, req_ch.frame_index, req_ch.pin_flag);
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_result('{frame: rsp_ch.frame, write_back: rsp_ch.write_back,
				status: rsp_ch.status});
	end

	task automatic put_request(input logic [TYPE_W-1:0] kind, input int idx, input int pin);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= kind;
		req_ch.frame_index <= idx[FRAME_W-1:0];
		req_ch.pin_flag    <= pin[0];
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
	endtask

	task automatic drain_replies();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic int any_frame();
		return $urandom_range(POOL_SIZE - 1);
	endfunction

	// runs of well-formed traffic with random content, plus some plain noise
	task automatic run_phase(input int items);
		int sent;
		int len;
		int pick;
		int sel;
		sent = 0;
		while (sent < items) begin
			pick = $urandom_range(99);
			if (pick < 15)
				len = $urandom_range(72, 20);
			else if (pick < 35)
				len = $urandom_range(40, 8);
			else if (pick < 45)
				len = $urandom_range(20, 5);
			else
				len = $urandom_range(40, 10);
			repeat (len) begin
				sel = $urandom_range(99);
				if (pick < 15) begin
					// pinning burst, drives the pool towards all frames pinned
					put_request(REQ_ACQUIRE, any_frame(), 1);
				end else if (pick < 35) begin
					put_request(REQ_SET_PIN, any_frame(), (sel < 10) ? 1 : 0);
				end else if (pick < 45) begin
					put_request(TYPE_W'($urandom_range(REQ_TOP_CODE)), any_frame(),
						$urandom_range(1));
				end else if (sel < 40) begin
					put_request(REQ_ACQUIRE, any_frame(), $urandom_range(1));
				end else if (sel < 60) begin
					put_request(REQ_MARK_DIRTY, any_frame(), $urandom_range(1));
				end else if (sel < 70) begin
					put_request(REQ_CLEAR_DIRTY, any_frame(), $urandom_range(1));
				end else if (sel < 80) begin
					put_request(REQ_FREE, any_frame(), $urandom_range(1));
				end else begin
					put_request(REQ_SET_PIN, any_frame(), $urandom_range(1));
				end
				sent++;
			end
		end
	endtask

	initial begin
		sb                 = new();
		arst_n             = 1'b0;
		tx_idle_pct        = 0;
		rx_idle_pct        = 0;
		req_ch.valid       = 1'b0;
		req_ch.req_type    = REQ_ACQUIRE;
		req_ch.frame_index = '0;
		req_ch.pin_flag    = 1'b0;
		rsp_ch.ready       = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 9;
		rx_idle_pct = 82;
		// requests on frames that are not resident, and unknown codes
		put_request(REQ_MARK_DIRTY, 0, 0);
		put_request(REQ_FREE, POOL_SIZE - 1, 1);
		put_request(REQ_SET_PIN, 5, 1);
		put_request(TYPE_W'(REQ_FREE + 1), 42, 1);
		put_request(REQ_TOP_CODE, 21, 0);
		// lowest free frame grants, then the per-frame requests on them
		put_request(REQ_ACQUIRE, 0, 0);
		put_request(REQ_ACQUIRE, POOL_SIZE - 1, 1);
		put_request(REQ_ACQUIRE, 7, 0);
		put_request(REQ_MARK_DIRTY, 2, 0);
		put_request(REQ_MARK_DIRTY, 1, 1);
		put_request(REQ_CLEAR_DIRTY, 1, 0);
		put_request(REQ_SET_PIN, 1, 0);
		put_request(REQ_SET_PIN, 0, 1);
		put_request(REQ_FREE, 1, 0);
		put_request(REQ_ACQUIRE, 0, 1);
		put_request(REQ_FREE, 0, 1);
		put_request(TYPE_W'(REQ_TOP_CODE - 1), POOL_SIZE - 1, 1);
		put_request(REQ_FREE, 2, 0);
		run_phase(ITEMS_PER_PHASE - 18);
		// hold the sender until the pipeline is empty
		drain_replies();

		tx_idle_pct = 82;
		rx_idle_pct = 9;
		run_phase(ITEMS_PER_PHASE);
		drain_replies();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_phase(ITEMS_PER_PHASE);
		drain_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);
		sb.close_out();

		$display("%0d requests: %0d free-frame grants, %0d clock victims (%0d %s)",
			sb.requests_seen, sb.fresh_grants, sb.victim_grants, sb.flushes,
			"with write-back");
		$display("%0d acquires refused with every frame pinned, %0d failures",
			sb.pool_exhausted, sb.failures);
		if (sb.failures == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d replies outstanding", sb.pending());
		$display("Verification failed");
		$finish;
	end

endmodule
